// ----- hdl/iaf_pkg.sv -----
// Package for the integer to ASCII formatter: command codes, character
// constants, the work record passed from front to back, and helpers.
// No dependencies.
package iaf_pkg;

  // Command codes carried on the input channel.
  localparam logic [1:0] CMD_SDEC = 2'd0;
  localparam logic [1:0] CMD_UDEC = 2'd1;
  localparam logic [1:0] CMD_LHEX = 2'd2;
  localparam logic [1:0] CMD_UHEX = 2'd3;

  // Character constants.
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;
  // Offsets that map digit values ten to fifteen onto letters.
  localparam logic [6:0] LOWER_OFS  = 7'd87;
  localparam logic [6:0] UPPER_OFS  = 7'd55;

  // Reciprocal of ten: floor(x * RECIP10 / 2**35) == x / 10 for any 32-bit x.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_IDX_W = 4;

  // One classified number, ready for conversion.
  typedef struct packed {
    logic        neg;    // print a leading minus sign
    logic        hex;    // base sixteen instead of ten
    logic        upper;  // uppercase hex letters
    logic [31:0] mag;    // unsigned magnitude to convert
  } iaf_job_t;

  // Digit value to its ASCII code.
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d, input logic upper);
    logic [6:0] ofs;
    begin
      if (d < 4'd10) begin
        ofs = CHAR_ZERO;
      end else if (upper) begin
        ofs = UPPER_OFS;
      end else begin
        ofs = LOWER_OFS;
      end
      digit_to_ascii = ofs + {3'b000, d};
    end
  endfunction

endpackage

// ----- hdl/iaf_if.sv -----
// Channel interfaces of the integer to ASCII formatter: the number channel
// and the character channel, each with valid/ready handshake. No dependencies.
interface iaf_num_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface iaf_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic [3:0] char_position;
  logic       last;

  modport source (output valid, output ascii_char, output char_position, output last,
                  input ready);
  modport sink (input valid, input ascii_char, input char_position, input last,
                output ready);
endinterface

// ----- hdl/iaf_front.sv -----
// Front part of the formatter: takes numbers, classifies them into a work
// record and holds up to two records in a queue. Depends on iaf_pkg, iaf_if.
module iaf_front (
  input  logic               clk,
  input  logic               rst,
  iaf_num_if.sink            num,
  output logic               job_valid,
  input  logic               job_ready,
  output iaf_pkg::iaf_job_t  job
);

  iaf_pkg::iaf_job_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  iaf_pkg::iaf_job_t classified;
  logic              push;
  logic              pop;

  always_comb begin
    classified.neg   = (num.command == iaf_pkg::CMD_SDEC) && num.value[31];
    classified.hex   = (num.command == iaf_pkg::CMD_LHEX) ||
                       (num.command == iaf_pkg::CMD_UHEX);
    classified.upper = (num.command == iaf_pkg::CMD_UHEX);
    classified.mag   = classified.neg ? (32'd0 - num.value) : num.value;
  end

  assign num.ready = (count != 2'd2);
  assign push      = num.valid && num.ready;
  assign job_valid = (count != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/iaf_back.sv -----
// Back part of the formatter: splits the magnitude into digits, least
// significant first, then sends the text out most significant first.
// Depends on iaf_pkg, iaf_if.
module iaf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  iaf_pkg::iaf_job_t  job,
  iaf_char_if.source         chars
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_REM  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t     state;
  logic [31:0] mag;
  logic [63:0] prod;
  logic        neg;
  logic        hex;
  logic        upper;
  logic [3:0]  digits [iaf_pkg::MAX_DIGITS];
  logic [iaf_pkg::DIGIT_IDX_W-1:0] cnt;
  logic [iaf_pkg::DIGIT_IDX_W-1:0] idx;
  logic        minus_pending;
  logic [3:0]  pos;

  logic        out_valid;
  logic [6:0]  out_char;
  logic [3:0]  out_pos;
  logic        out_last;

  logic [31:0] quo;
  logic [31:0] quo_times10;
  logic [31:0] diff;
  logic [3:0]  rem;
  logic        advance;

  assign job_ready = (state == S_IDLE);
  assign advance   = !out_valid || chars.ready;

  // Quotient and remainder of one digit step.
  always_comb begin
    if (hex) begin
      quo = {4'b0000, mag[31:4]};
    end else begin
      quo = {3'b000, prod[63:iaf_pkg::RECIP_SHIFT]};
    end
    quo_times10 = {quo[28:0], 3'b000} + {quo[30:0], 1'b0};
    diff        = mag - quo_times10;
    rem         = hex ? mag[3:0] : diff[3:0];
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= 64'(mag) * 64'(iaf_pkg::RECIP10);
    end
    if (state == S_REM) begin
      digits[cnt] <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (chars.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            mag   <= job.mag;
            neg   <= job.neg;
            hex   <= job.hex;
            upper <= job.upper;
            cnt   <= '0;
            state <= job.hex ? S_REM : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_REM;
        end
        S_REM: begin
          mag <= quo;
          cnt <= cnt + (iaf_pkg::DIGIT_IDX_W)'(1);
          if (quo == 32'd0) begin
            idx           <= cnt;
            minus_pending <= neg;
            pos           <= 4'd1;
            state         <= S_EMIT;
          end else begin
            state <= hex ? S_REM : S_MUL;
          end
        end
        S_EMIT: begin
          if (advance) begin
            out_valid <= 1'b1;
            out_pos   <= pos;
            pos       <= pos + 4'd1;
            if (minus_pending) begin
              out_char      <= iaf_pkg::CHAR_MINUS;
              out_last      <= 1'b0;
              minus_pending <= 1'b0;
            end else begin
              out_char <= iaf_pkg::digit_to_ascii(digits[idx], upper);
              out_last <= (idx == '0);
              if (idx == '0) begin
                state <= S_IDLE;
              end else begin
                idx <= idx - (iaf_pkg::DIGIT_IDX_W)'(1);
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign chars.valid         = out_valid;
  assign chars.ascii_char    = out_char;
  assign chars.char_position = out_pos;
  assign chars.last          = out_last;

endmodule

// ----- hdl/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter. Connects the front part
// (iaf_front) and the back part (iaf_back). Depends on iaf_pkg, iaf_if.

// Each number transferred on the num channel, with a command for signed
// decimal, unsigned decimal, lowercase hex or uppercase hex, comes out on the
// chars channel as ASCII text, one character per transfer, most significant
// digit first, with no leading zeros; zero prints as a single "0", and a
// negative signed value gets a leading minus sign. Every character carries its
// position in the text, counting from one, and the last flag marks the final
// character of each number. The converter picks up a number from the queue,
// then works out its digits (for each decimal digit a registered multiply
// by the reciprocal of ten, then the remainder step; for each hex digit the
// remainder step alone), then sends one character per cycle while the chars
// side keeps ready high. A two-entry queue between the input side and the
// converter lets numbers be taken while earlier text is still going out,
// and the last character stays on the chars channel until it is taken.
module integer_to_ascii_formatter (
  input logic         clk,
  input logic         rst,
  iaf_num_if.sink     num,
  iaf_char_if.source  chars
);

  // Classified numbers waiting for the converter.
  logic              job_valid;
  logic              job_ready;
  iaf_pkg::iaf_job_t job;

  iaf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .num       (num),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // Digit conversion and character output.
  iaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .chars     (chars)
  );

endmodule

// ----- hdl/iaf_checker.sv -----
// Port checker for the integer to ASCII formatter and its bind to the top
// level. Depends on iaf_pkg and integer_to_ascii_formatter.
module iaf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic [3:0] out_pos,
  input logic       out_last
);

  // A stalled character stays as it is.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(out_pos) && $stable(out_last))
    else $error("character changed while stalled");

  // Positions run from one to eleven.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pos >= 4'd1 && out_pos <= 4'd11)
    else $error("character position out of range");

  // A minus sign only opens the text.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == iaf_pkg::CHAR_MINUS |-> out_pos == 4'd1 && !out_last)
    else $error("minus sign misplaced");

  // A leading zero is only the whole text of zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pos == 4'd1 && out_char == iaf_pkg::CHAR_ZERO |-> out_last)
    else $error("leading zero");

endmodule

bind integer_to_ascii_formatter iaf_checker u_iaf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .out_char  (chars.ascii_char),
  .out_pos   (chars.char_position),
  .out_last  (chars.last)
);

// ----- sim/iaf_text_checker.sv -----
`timescale 1ns / 1ps
// Checker for the integer to ASCII formatter: watches the number and character
// channels, predicts the text of every number and compares it character by
// character. Depends on iaf_pkg and iaf_if.
module iaf_text_checker (
  input  logic  clk,
  input  logic  rst,
  iaf_num_if    num,
  iaf_char_if   chars,
  output int    fail_count,
  output int    chars_pending
);

  typedef struct packed {
    logic [6:0] ascii_char;
    logic [3:0] char_position;
    logic       last;
  } text_char_t;

  localparam string HEX_LOWER = "0123456789abcdef";
  localparam string HEX_UPPER = "0123456789ABCDEF";

  text_char_t expected_text[$];
  int         errors = 0;
  int         pending = 0;

  assign fail_count    = errors;
  assign chars_pending = pending;

  // Appends the characters that one number must produce.
  function automatic void format_number(input logic [1:0] cmd, input logic [31:0] val);
    logic [31:0] mag;
    logic        negative;
    logic [3:0]  digits[11];
    int          ndig;
    int          total;
    int          pos;
    byte         glyph;
    text_char_t  entry;
    negative = (cmd == iaf_pkg::CMD_SDEC) && val[31];
    mag      = negative ? (32'd0 - val) : val;
    ndig     = 0;
    do begin
      if (cmd == iaf_pkg::CMD_SDEC || cmd == iaf_pkg::CMD_UDEC) begin
        digits[ndig] = 4'(mag % 32'd10);
        mag          = mag / 32'd10;
      end else begin
        digits[ndig] = mag[3:0];
        mag          = mag >> 4;
      end
      ndig++;
    end while (mag != 32'd0);
    total = ndig + (negative ? 1 : 0);
    pos   = 1;
    if (negative) begin
      entry = '{ascii_char: 7'(8'h2D), char_position: 4'(pos), last: 1'b0};
      expected_text.push_back(entry);
      pos++;
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      glyph = (cmd == iaf_pkg::CMD_UHEX) ? HEX_UPPER[digits[i]] : HEX_LOWER[digits[i]];
      entry = '{ascii_char: glyph[6:0], char_position: 4'(pos), last: (pos == total)};
      expected_text.push_back(entry);
      pos++;
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (num.valid && num.ready) begin
        format_number(num.command, num.value);
      end
      if (chars.valid && chars.ready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual char %0d pos %0d last %0b",
                   $time, chars.ascii_char, chars.char_position, chars.last);
          errors++;
        end else begin
          want = expected_text.pop_front();
          if (chars.ascii_char !== want.ascii_char) begin
            $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                     $time, want.ascii_char, chars.ascii_char);
            errors++;
          end
          if (chars.char_position !== want.char_position) begin
            $display("%0t: char_position mismatch: expected %0d, actual %0d",
                     $time, want.char_position, chars.char_position);
            errors++;
          end
          if (chars.last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, chars.last);
            errors++;
          end
        end
      end
    end
    pending = expected_text.size();
  end

endmodule

// ----- sim/integer_to_ascii_formatter_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the integer to ASCII formatter: clock, reset, number
// stimulus and character back-pressure, with iaf_text_checker doing the
// prediction. Depends on iaf_pkg, iaf_if, iaf_text_checker and the RTL.
module integer_to_ascii_formatter_tb;

  // The run is cut off here; the slowest legal run needs far fewer cycles.
  localparam int CYCLE_LIMIT  = 400000;
  // Cycles the receiver refuses characters during the back-pressure test.
  localparam int HOLD_CYCLES  = 300;
  // Drain time once nothing is expected: above one full signed decimal number.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 36;
  localparam int BURST_ITEMS  = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iaf_num_if  num();
  iaf_char_if chars();

  int fail_count;
  int chars_pending;
  int cycle_count = 0;

  // Idle percentages for the sender and the receiver; changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Set by the stimulus to make the receiver stall for HOLD_CYCLES.
  logic hold_start = 1'b0;

  always #4 clk = ~clk;

  integer_to_ascii_formatter DUT (
    .clk   (clk),
    .rst   (rst),
    .num   (num),
    .chars (chars)
  );

  iaf_text_checker text_checker (
    .clk           (clk),
    .rst           (rst),
    .num           (num),
    .chars         (chars),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  // Watchdog. If the block hangs, this is the only way the run ends.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver side. Ready changes only at the falling edge. When a hold is
  // requested, ready stays low for HOLD_CYCLES while the sender keeps
  // offering numbers, so the internal queue fills and num.ready drops.
  initial begin
    chars.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        repeat (HOLD_CYCLES) begin
          chars.ready <= 1'b0;
          @(negedge clk);
        end
      end
      chars.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one number and returns at the falling edge after its transfer.
  // Each falling edge sees exactly one assignment to num.valid: either the
  // idle lowering or the raise for this number, never both.
  task automatic send_number(input logic [1:0] cmd, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      num.valid <= 1'b0;
      @(negedge clk);
    end
    num.valid   <= 1'b1;
    num.command <= cmd;
    num.value   <= val;
    do @(posedge clk); while (!num.ready);
    @(negedge clk);
  endtask

  // Random operands of mixed shapes: full 32-bit patterns so every bit
  // toggles, short decimals, values of random length, and small negatives.
  function automatic logic [31:0] random_operand();
    logic [31:0] val;
    case ($urandom_range(3))
      0: val = $urandom;
      1: val = $urandom_range(999);
      2: val = $urandom >> $urandom_range(31);
      default: val = 32'd0 - $urandom_range(1000, 1);
    endcase
    return val;
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_number(2'($urandom_range(3)), random_operand());
    end
  endtask

  initial begin
    logic [1:0]  all_cmds[4];
    logic [31:0] edge_vals[3];
    all_cmds  = '{iaf_pkg::CMD_SDEC, iaf_pkg::CMD_UDEC, iaf_pkg::CMD_LHEX,
                  iaf_pkg::CMD_UHEX};
    // Zero, all ones (minus one when signed) and the most negative value.
    edge_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};

    num.valid   = 1'b0;
    num.command = iaf_pkg::CMD_SDEC;
    num.value   = 32'd0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: sender idles rarely, receiver idles most of the time.
    send_idle_pct = 11;
    recv_idle_pct = 83;

    // Directed numbers: every command on the edge values, then the largest
    // positive, single-digit and digit-rollover cases and both hex cases.
    foreach (edge_vals[v]) begin
      foreach (all_cmds[c]) begin
        send_number(all_cmds[c], edge_vals[v]);
      end
    end
    send_number(iaf_pkg::CMD_SDEC, 32'h7FFF_FFFF);
    send_number(iaf_pkg::CMD_UDEC, 32'h7FFF_FFFF);
    send_number(iaf_pkg::CMD_SDEC, 32'd1);
    send_number(iaf_pkg::CMD_UDEC, 32'd9);
    send_number(iaf_pkg::CMD_SDEC, 32'd10);
    send_number(iaf_pkg::CMD_LHEX, 32'h0000_000F);
    send_number(iaf_pkg::CMD_UHEX, 32'h0000_0010);
    send_number(iaf_pkg::CMD_LHEX, 32'hABCD_EF01);
    send_number(iaf_pkg::CMD_UHEX, 32'hABCD_EF01);
    send_number(iaf_pkg::CMD_UDEC, 32'd1_000_000_000);

    send_random(PHASE_ITEMS);

    // Phase two: the roles swap.
    send_idle_pct = 83;
    recv_idle_pct = 11;
    send_random(PHASE_ITEMS);

    // Phase three: both sides at full speed.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(PHASE_ITEMS);

    // Back-pressure: the receiver stalls for a long stretch while numbers
    // keep coming, so the block must hold off the number channel. The
    // number channel goes idle first so the last number is not offered twice.
    num.valid <= 1'b0;
    @(posedge clk);
    hold_start = 1'b1;
    @(negedge clk);
    send_random(BURST_ITEMS);
    num.valid <= 1'b0;

    // Wait until every predicted character has arrived, then give the
    // block time to show any stray extra transfer.
    wait (chars_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && chars_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/iaf_pkg.sv
hdl/iaf_if.sv
hdl/iaf_front.sv
hdl/iaf_back.sv
hdl/integer_to_ascii_formatter.sv
hdl/iaf_checker.sv
sim/iaf_text_checker.sv
sim/integer_to_ascii_formatter_tb.sv
